// ===== rtl/bc_block_mode_classifier_assert.svh =====
// Assertion macros for the block mode classifier.
`ifndef BC_BLOCK_MODE_CLASSIFIER_ASSERT_SVH
`define BC_BLOCK_MODE_CLASSIFIER_ASSERT_SVH

// Antecedent in the same cycle implies the consequent.
`define BCMC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies the consequent in the following cycle.
`define BCMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bcmc_pkg.sv =====
package bcmc_pkg;

	localparam int MAX_SAMPLES    = 32;
	localparam int CNT_W          = 6;
	localparam int NZ_TOTAL_W     = 10;
	localparam int MODE_W         = 4;
	localparam int BLOCK_NZ_W     = 5;
	localparam int LANE_BYTES     = 8;
	localparam int LANE_NZ_W      = 4;
	localparam int HALF_W         = 64;
	localparam int CFG_DATA_W     = 6;

	localparam logic [MODE_W-1:0] MODE_RESERVED = 4'd15;

	typedef enum logic {
		CFG_BLOCK_FORMAT = 1'b0,
		CFG_SAMPLE_CAP   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FMT_BC6H_UF = 1'b0,
		FMT_BC7     = 1'b1
	} fmt_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              defined;
	} mode_info_t;

endpackage

// ===== rtl/bcmc_nz_lane.sv =====
module bcmc_nz_lane (
	input  logic [bcmc_pkg::HALF_W-1:0]    half,
	output logic [bcmc_pkg::LANE_NZ_W-1:0] count
);

	always_comb begin
		count = '0;
		for (int i = 0; i < bcmc_pkg::LANE_BYTES; i++) begin
			count = count + bcmc_pkg::LANE_NZ_W'(|half[8*i +: 8]);
		end
	end

endmodule

// ===== rtl/bcmc_mode_dec.sv =====
module bcmc_mode_dec (
	input  logic [7:0]           byte0,
	input  bcmc_pkg::fmt_t       fmt,
	output bcmc_pkg::mode_info_t info
);

	logic [bcmc_pkg::MODE_W-1:0] bc6h_mode;
	logic [bcmc_pkg::MODE_W-1:0] bc7_mode;

	always_comb begin
		if (byte0[1:0] < 2'd2) begin
			bc6h_mode = bcmc_pkg::MODE_W'(byte0[1:0]);
		end else begin
			unique case (byte0[4:0])
				5'h02:   bc6h_mode = 4'd2;
				5'h06:   bc6h_mode = 4'd3;
				5'h0A:   bc6h_mode = 4'd4;
				5'h0E:   bc6h_mode = 4'd5;
				5'h12:   bc6h_mode = 4'd6;
				5'h16:   bc6h_mode = 4'd7;
				5'h1A:   bc6h_mode = 4'd8;
				5'h1E:   bc6h_mode = 4'd9;
				5'h03:   bc6h_mode = 4'd10;
				5'h07:   bc6h_mode = 4'd11;
				5'h0B:   bc6h_mode = 4'd12;
				5'h0F:   bc6h_mode = 4'd13;
				default: bc6h_mode = bcmc_pkg::MODE_RESERVED;
			endcase
		end
	end

	// lowest set bit of byte 0; a zero byte is reserved
	always_comb begin
		bc7_mode = bcmc_pkg::MODE_RESERVED;
		for (int m = 7; m >= 0; m--) begin
			if (byte0[m]) begin
				bc7_mode = bcmc_pkg::MODE_W'(m);
			end
		end
	end

	always_comb begin
		info.mode    = (fmt == bcmc_pkg::FMT_BC7) ? bc7_mode : bc6h_mode;
		info.defined = (info.mode != bcmc_pkg::MODE_RESERVED);
	end

endmodule

// ===== rtl/bc_block_mode_classifier.sv =====
// Block mode classifier: one 16-byte BC6H (unsigned float) or BC7 block per item.
// Input channel: in_valid/in_stall with block_low, block_high and start_face.
// An item is taken on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall, one result item per input item.
// Configuration: cfg_valid/cfg_ready (ready always high), cfg_index selects
// block_format (0) or the per-face sample cap (1), cfg_data carries the value.
// Two byte lanes count nonzero bytes of each 64-bit half while the mode
// decoder reads byte 0; the merge step adds the lane counts and updates
// the per-face totals.
// Results are registered; out_valid rises on the edge that takes the item. One item
// per cycle is sustained while out_stall is low; the per-face totals update as each item is taken.
// While out_stall holds a pending result, in_stall is raised and the result
// and totals hold. Reset clears all totals and the first mode, sets
// block_format to BC6H and the sample cap to 32, and empties the output register.
module bc_block_mode_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bcmc_pkg::HALF_W-1:0]         block_low,
	input  logic [bcmc_pkg::HALF_W-1:0]         block_high,
	input  logic                                start_face,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                accepted,
	output logic [bcmc_pkg::MODE_W-1:0]         mode,
	output logic                                defined,
	output logic [bcmc_pkg::BLOCK_NZ_W-1:0]     block_nonzero,
	output logic [bcmc_pkg::CNT_W-1:0]          sampled_total,
	output logic [bcmc_pkg::CNT_W-1:0]          defined_total,
	output logic [bcmc_pkg::CNT_W-1:0]          reserved_total,
	output logic [bcmc_pkg::NZ_TOTAL_W-1:0]     nonzero_total,
	output logic [bcmc_pkg::MODE_W-1:0]         face_first_mode,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  bcmc_pkg::cfg_reg_t                  cfg_index,
	input  logic [bcmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	`include "bc_block_mode_classifier_assert.svh"

	localparam logic [bcmc_pkg::CNT_W-1:0] MAX_CNT = bcmc_pkg::CNT_W'(bcmc_pkg::MAX_SAMPLES);

	bcmc_pkg::fmt_t                  fmt_q;
	logic [bcmc_pkg::CNT_W-1:0]      cap_cfg_q;
	logic [bcmc_pkg::CNT_W-1:0]      sample_q;
	logic [bcmc_pkg::CNT_W-1:0]      defined_q;
	logic [bcmc_pkg::CNT_W-1:0]      reserved_q;
	logic [bcmc_pkg::NZ_TOTAL_W-1:0] nonzero_q;
	logic [bcmc_pkg::MODE_W-1:0]     lead_mode_q;
	logic                            out_valid_q;
	logic                            accepted_q;
	logic [bcmc_pkg::MODE_W-1:0]     mode_q;
	logic                            defined_flag_q;
	logic [bcmc_pkg::BLOCK_NZ_W-1:0] block_nz_q;

	logic [bcmc_pkg::LANE_NZ_W-1:0]  lane_lo_nz;
	logic [bcmc_pkg::LANE_NZ_W-1:0]  lane_hi_nz;
	bcmc_pkg::mode_info_t            info;
	logic [bcmc_pkg::BLOCK_NZ_W-1:0] block_nz;
	logic [bcmc_pkg::CNT_W-1:0]      limit;
	logic [bcmc_pkg::CNT_W-1:0]      base_sample;
	logic [bcmc_pkg::CNT_W-1:0]      base_defined;
	logic [bcmc_pkg::CNT_W-1:0]      base_reserved;
	logic [bcmc_pkg::NZ_TOTAL_W-1:0] base_nonzero;
	logic                            take;
	logic                            item_in;

	bcmc_nz_lane u_lane_lo (
		.half  (block_low),
		.count (lane_lo_nz)
	);

	bcmc_nz_lane u_lane_hi (
		.half  (block_high),
		.count (lane_hi_nz)
	);

	bcmc_mode_dec u_mode_dec (
		.byte0 (block_low[7:0]),
		.fmt   (fmt_q),
		.info  (info)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign item_in   = in_valid && !in_stall;

	// merge lane counts
	assign block_nz = bcmc_pkg::BLOCK_NZ_W'(lane_lo_nz) + bcmc_pkg::BLOCK_NZ_W'(lane_hi_nz);

	always_comb begin
		if (cap_cfg_q == '0) begin
			limit = bcmc_pkg::CNT_W'(1);
		end else if (cap_cfg_q > MAX_CNT) begin
			limit = MAX_CNT;
		end else begin
			limit = cap_cfg_q;
		end
	end

	always_comb begin
		base_sample   = start_face ? '0 : sample_q;
		base_defined  = start_face ? '0 : defined_q;
		base_reserved = start_face ? '0 : reserved_q;
		base_nonzero  = start_face ? '0 : nonzero_q;
		take          = base_sample < limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= bcmc_pkg::FMT_BC6H_UF;
			cap_cfg_q <= MAX_CNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bcmc_pkg::CFG_BLOCK_FORMAT: fmt_q <= bcmc_pkg::fmt_t'(cfg_data[0]);
				bcmc_pkg::CFG_SAMPLE_CAP:   cap_cfg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q    <= '0;
			defined_q   <= '0;
			reserved_q  <= '0;
			nonzero_q   <= '0;
			lead_mode_q <= '0;
		end else if (item_in) begin
			if (take) begin
				sample_q   <= base_sample + bcmc_pkg::CNT_W'(1);
				defined_q  <= base_defined + bcmc_pkg::CNT_W'(info.defined);
				reserved_q <= base_reserved + bcmc_pkg::CNT_W'(!info.defined);
				nonzero_q  <= base_nonzero + bcmc_pkg::NZ_TOTAL_W'(block_nz);
				if (base_sample == '0) begin
					lead_mode_q <= info.mode;
				end
			end else begin
				sample_q   <= base_sample;
				defined_q  <= base_defined;
				reserved_q <= base_reserved;
				nonzero_q  <= base_nonzero;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_in) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in) begin
			accepted_q     <= take;
			mode_q         <= info.mode;
			defined_flag_q <= info.defined;
			block_nz_q     <= block_nz;
		end
	end

	// totals change only with a new item, so they stand with the held result
	assign out_valid       = out_valid_q;
	assign accepted        = accepted_q;
	assign mode            = mode_q;
	assign defined         = defined_flag_q;
	assign block_nonzero   = block_nz_q;
	assign sampled_total   = sample_q;
	assign defined_total   = defined_q;
	assign reserved_total  = reserved_q;
	assign nonzero_total   = nonzero_q;
	assign face_first_mode = lead_mode_q;

	`BCMC_ASSERT_SAME(a_totals_split, out_valid_q,
		({1'b0, defined_q} + {1'b0, reserved_q}) == {1'b0, sample_q},
		"defined and reserved totals do not add up to sampled total")
	`BCMC_ASSERT_SAME(a_accept_in_range, out_valid_q && accepted_q,
		(sample_q != '0) && (sample_q <= MAX_CNT),
		"accepted block left sampled total out of range")
	`BCMC_ASSERT_SAME(a_reserved_code, out_valid_q && !defined_flag_q,
		mode_q == bcmc_pkg::MODE_RESERVED, "undefined block without reserved mode")
	`BCMC_ASSERT_NEXT(a_result_follows, item_in, out_valid_q,
		"taken item produced no result")

endmodule

// ===== tb/sv/tb_bc_block_mode_classifier.sv =====
module tb_bc_block_mode_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_REPORTS = 50;

	// BC6H 5-bit prefixes: every table entry plus two reserved codes
	localparam logic [4:0] BC6H_PREFIX [16] = '{
		5'h00, 5'h01, 5'h02, 5'h06, 5'h0A, 5'h0E, 5'h12, 5'h16,
		5'h1A, 5'h1E, 5'h03, 5'h07, 5'h0B, 5'h0F, 5'h13, 5'h1F
	};

	// sample limits per random phase; negative slots draw a random limit
	localparam int LIMIT_PLAN [8] = '{32, 0, 63, 1, 33, -1, 31, -1};

	typedef struct packed {
		logic                            accepted;
		logic [bcmc_pkg::MODE_W-1:0]     mode;
		logic                            defined;
		logic [bcmc_pkg::BLOCK_NZ_W-1:0] block_nonzero;
		logic [bcmc_pkg::CNT_W-1:0]      sampled_total;
		logic [bcmc_pkg::CNT_W-1:0]      defined_total;
		logic [bcmc_pkg::CNT_W-1:0]      reserved_total;
		logic [bcmc_pkg::NZ_TOTAL_W-1:0] nonzero_total;
		logic [bcmc_pkg::MODE_W-1:0]     face_first_mode;
	} block_verdict_t;

	class face_tally;
		bcmc_pkg::fmt_t                  block_format;
		logic [bcmc_pkg::CFG_DATA_W-1:0] cap_setting;
		logic [bcmc_pkg::CNT_W-1:0]      sample_count;
		logic [bcmc_pkg::CNT_W-1:0]      defined_count;
		logic [bcmc_pkg::CNT_W-1:0]      reserved_count;
		logic [bcmc_pkg::NZ_TOTAL_W-1:0] nonzero_count;
		logic [bcmc_pkg::MODE_W-1:0]     lead_mode;
		block_verdict_t                  pending[$];
		int errors;
		int blocks_seen;
		int results_seen;
		int blocks_counted;
		int faces_started;
		int reg_writes;

		function new();
			block_format   = bcmc_pkg::FMT_BC6H_UF;
			cap_setting    = bcmc_pkg::CFG_DATA_W'(bcmc_pkg::MAX_SAMPLES);
			sample_count   = '0;
			defined_count  = '0;
			reserved_count = '0;
			nonzero_count  = '0;
			lead_mode      = '0;
			errors         = 0;
			blocks_seen    = 0;
			results_seen   = 0;
			blocks_counted = 0;
			faces_started  = 0;
			reg_writes     = 0;
		endfunction

		function void set_register(bcmc_pkg::cfg_reg_t idx,
				logic [bcmc_pkg::CFG_DATA_W-1:0] val);
			reg_writes++;
			case (idx)
				bcmc_pkg::CFG_BLOCK_FORMAT: block_format = bcmc_pkg::fmt_t'(val[0]);
				bcmc_pkg::CFG_SAMPLE_CAP:   cap_setting = val;
				default:                    ;
			endcase
		endfunction

		function logic [bcmc_pkg::MODE_W-1:0] bc6h_mode(logic [7:0] b0);
			if (b0[1:0] < 2'd2)
				return bcmc_pkg::MODE_W'(b0[1:0]);
			case (b0[4:0])
				5'h02: return 4'd2;
				5'h06: return 4'd3;
				5'h0A: return 4'd4;
				5'h0E: return 4'd5;
				5'h12: return 4'd6;
				5'h16: return 4'd7;
				5'h1A: return 4'd8;
				5'h1E: return 4'd9;
				5'h03: return 4'd10;
				5'h07: return 4'd11;
				5'h0B: return 4'd12;
				5'h0F: return 4'd13;
				default: return bcmc_pkg::MODE_RESERVED;
			endcase
		endfunction

		function logic [bcmc_pkg::MODE_W-1:0] bc7_mode(logic [7:0] b0);
			for (int k = 0; k < 8; k++)
				if (b0[k])
					return bcmc_pkg::MODE_W'(k);
			return bcmc_pkg::MODE_RESERVED;
		endfunction

		function logic [bcmc_pkg::BLOCK_NZ_W-1:0] count_nonzero(logic [63:0] lo,
				logic [63:0] hi);
			logic [bcmc_pkg::BLOCK_NZ_W-1:0] n;
			n = '0;
			for (int k = 0; k < bcmc_pkg::LANE_BYTES; k++) begin
				if (lo[8*k +: 8] != 8'h00)
					n++;
				if (hi[8*k +: 8] != 8'h00)
					n++;
			end
			return n;
		endfunction

		function int clamp_cap();
			if (cap_setting == '0)
				return 1;
			if (cap_setting > bcmc_pkg::MAX_SAMPLES)
				return bcmc_pkg::MAX_SAMPLES;
			return cap_setting;
		endfunction

		function void note_block(logic [63:0] lo, logic [63:0] hi, logic sf);
			block_verdict_t v;
			if (sf) begin
				sample_count   = '0;
				defined_count  = '0;
				reserved_count = '0;
				nonzero_count  = '0;
				faces_started++;
			end
			v.mode = (block_format == bcmc_pkg::FMT_BC7) ? bc7_mode(lo[7:0])
				: bc6h_mode(lo[7:0]);
			v.defined = (v.mode != bcmc_pkg::MODE_RESERVED);
			v.block_nonzero = count_nonzero(lo, hi);
			v.accepted = (sample_count < clamp_cap());
			if (v.accepted) begin
				// the first counted block of a face latches its mode
				if (sample_count == '0)
					lead_mode = v.mode;
				sample_count++;
				defined_count  += bcmc_pkg::CNT_W'(v.defined);
				reserved_count += bcmc_pkg::CNT_W'(!v.defined);
				nonzero_count  += bcmc_pkg::NZ_TOTAL_W'(v.block_nonzero);
				blocks_counted++;
			end
			v.sampled_total   = sample_count;
			v.defined_total   = defined_count;
			v.reserved_total  = reserved_count;
			v.nonzero_total   = nonzero_count;
			v.face_first_mode = lead_mode;
			pending.push_back(v);
			blocks_seen++;
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_REPORTS)
				$display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
			errors++;
		endtask

		task compare_field(string name, logic [bcmc_pkg::NZ_TOTAL_W-1:0] got,
				logic [bcmc_pkg::NZ_TOTAL_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_result(block_verdict_t got);
			block_verdict_t want;
			results_seen++;
			if (pending.size() == 0) begin
				report_mismatch("result arrived with no block outstanding");
				return;
			end
			want = pending.pop_front();
			compare_field("accepted", got.accepted, want.accepted);
			compare_field("mode", got.mode, want.mode);
			compare_field("defined", got.defined, want.defined);
			compare_field("block_nonzero", got.block_nonzero, want.block_nonzero);
			compare_field("sampled_total", got.sampled_total, want.sampled_total);
			compare_field("defined_total", got.defined_total, want.defined_total);
			compare_field("reserved_total", got.reserved_total, want.reserved_total);
			compare_field("nonzero_total", got.nonzero_total, want.nonzero_total);
			compare_field("face_first_mode", got.face_first_mode, want.face_first_mode);
		endtask
	endclass

	logic                            clk;
	logic                            arst_n     = 1'b0;
	logic                            in_valid   = 1'b0;
	logic                            in_stall;
	logic [bcmc_pkg::HALF_W-1:0]     block_low  = '0;
	logic [bcmc_pkg::HALF_W-1:0]     block_high = '0;
	logic                            start_face = 1'b0;
	logic                            out_valid;
	logic                            out_stall  = 1'b0;
	logic                            accepted;
	logic [bcmc_pkg::MODE_W-1:0]     mode;
	logic                            defined;
	logic [bcmc_pkg::BLOCK_NZ_W-1:0] block_nonzero;
	logic [bcmc_pkg::CNT_W-1:0]      sampled_total;
	logic [bcmc_pkg::CNT_W-1:0]      defined_total;
	logic [bcmc_pkg::CNT_W-1:0]      reserved_total;
	logic [bcmc_pkg::NZ_TOTAL_W-1:0] nonzero_total;
	logic [bcmc_pkg::MODE_W-1:0]     face_first_mode;
	logic                            cfg_valid  = 1'b0;
	logic                            cfg_ready;
	bcmc_pkg::cfg_reg_t              cfg_index  = bcmc_pkg::CFG_BLOCK_FORMAT;
	logic [bcmc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

	face_tally      tally;
	block_verdict_t seen;
	int             quiet_cycles = 0;
	int             burst_left   = 0;
	int             stall_style  = 0;
	int             stall_left   = 0;
	int             stall_tick   = 0;

	bc_block_mode_classifier dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.block_low       (block_low),
		.block_high      (block_high),
		.start_face      (start_face),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.mode            (mode),
		.defined         (defined),
		.block_nonzero   (block_nonzero),
		.sampled_total   (sampled_total),
		.defined_total   (defined_total),
		.reserved_total  (reserved_total),
		.nonzero_total   (nonzero_total),
		.face_first_mode (face_first_mode),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: switch between four stall styles, each held for a random stretch
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(40, 250);
		end
		stall_left--;
		stall_tick++;
		case (stall_style)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= ((stall_tick % 5) < 2);
		endcase
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (cfg_valid && cfg_ready) begin
				tally.set_register(cfg_index, cfg_data);
				quiet_cycles = 0;
			end
			if (in_valid && !in_stall) begin
				tally.note_block(block_low, block_high, start_face);
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				seen.accepted        = accepted;
				seen.mode            = mode;
				seen.defined         = defined;
				seen.block_nonzero   = block_nonzero;
				seen.sampled_total   = sampled_total;
				seen.defined_total   = defined_total;
				seen.reserved_total  = reserved_total;
				seen.nonzero_total   = nonzero_total;
				seen.face_first_mode = face_first_mode;
				tally.check_result(seen);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_half();
		logic [63:0] h;
		int          zero_odds;
		zero_odds = $urandom_range(0, 4);
		for (int b = 0; b < bcmc_pkg::LANE_BYTES; b++)
			h[8*b +: 8] = ($urandom_range(0, 3) < zero_odds) ? 8'h00 : 8'($urandom);
		return h;
	endfunction

	// byte whose lowest set bit is at position k
	function automatic logic [7:0] low_bit_byte(int k);
		return 8'(($urandom | 32'd1) << k);
	endfunction

	function automatic logic [7:0] pick_byte0();
		case ($urandom_range(0, 9))
			0:          return 8'h00;
			1, 2, 3, 4: return {3'($urandom), BC6H_PREFIX[$urandom_range(0, 15)]};
			5, 6, 7:    return low_bit_byte($urandom_range(0, 7));
			default:    return 8'($urandom);
		endcase
	endfunction

	task automatic write_reg(bcmc_pkg::cfg_reg_t idx, logic [bcmc_pkg::CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic sf);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		block_low  <= lo;
		block_high <= hi;
		start_face <= sf;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tally.pending.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_phase(int n_blocks);
		int          face_left;
		logic        sf;
		logic [63:0] lo;
		logic [63:0] hi;
		face_left = $urandom_range(1, 36);
		// half the time keep the face left over from the previous setting
		sf = 1'($urandom_range(0, 1));
		for (int i = 0; i < n_blocks; i++) begin
			if (face_left == 0) begin
				face_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 45)
					: $urandom_range(1, 36);
				sf = 1'b1;
			end else if ($urandom_range(0, 49) == 0) begin
				sf = 1'b1;
			end
			lo = rand_half();
			hi = rand_half();
			lo[7:0] = pick_byte0();
			send_block(lo, hi, sf);
			sf = 1'b0;
			face_left--;
		end
	endtask

	initial begin
		logic [63:0]    lo;
		logic [63:0]    hi;
		bcmc_pkg::fmt_t fmt;
		int             lim;
		tally = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// BC6H: every prefix, the first block after reset joins the face
		write_reg(bcmc_pkg::CFG_BLOCK_FORMAT, bcmc_pkg::CFG_DATA_W'(bcmc_pkg::FMT_BC6H_UF));
		write_reg(bcmc_pkg::CFG_SAMPLE_CAP, bcmc_pkg::CFG_DATA_W'(bcmc_pkg::MAX_SAMPLES));
		for (int i = 0; i < 16; i++) begin
			lo = rand_half();
			hi = rand_half();
			lo[7:0] = {3'($urandom), BC6H_PREFIX[i]};
			if (i == 0) begin
				lo = '0;
				hi = '0;
			end
			if (i == 15) begin
				lo = '1;
				hi = '1;
			end
			send_block(lo, hi, 1'b0);
		end
		settle();

		// BC7 with a zero limit: zero byte 0 first, then each lowest-bit position
		write_reg(bcmc_pkg::CFG_BLOCK_FORMAT, bcmc_pkg::CFG_DATA_W'(bcmc_pkg::FMT_BC7));
		write_reg(bcmc_pkg::CFG_SAMPLE_CAP, '0);
		for (int k = -1; k < 8; k++) begin
			lo = rand_half();
			hi = rand_half();
			lo[7:0] = (k < 0) ? 8'h00 : low_bit_byte(k);
			send_block(lo, hi, k < 0);
		end
		settle();

		for (int p = 0; p < 8; p++) begin
			fmt = (p < 2) ? bcmc_pkg::fmt_t'(p[0]) : bcmc_pkg::fmt_t'($urandom_range(0, 1));
			lim = (LIMIT_PLAN[p] < 0) ? $urandom_range(0, 63) : LIMIT_PLAN[p];
			write_reg(bcmc_pkg::CFG_BLOCK_FORMAT, bcmc_pkg::CFG_DATA_W'(fmt));
			write_reg(bcmc_pkg::CFG_SAMPLE_CAP, bcmc_pkg::CFG_DATA_W'(lim));
			run_phase(115);
			settle();
		end

		repeat (4) @(posedge clk);
		if (tally.pending.size() != 0)
			tally.report_mismatch($sformatf("%0d results never arrived",
				tally.pending.size()));

		$display("Checked %0d results for %0d blocks, %0d counted into face totals",
			tally.results_seen, tally.blocks_seen, tally.blocks_counted);
		$display("Covered %0d face starts over %0d register writes, BC6H and BC7, limits 0..63",
			tally.faces_started, tally.reg_writes);
		if (tally.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
